>>> design/ilid_pkg.sv
package ilid_pkg;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W    = $clog2(DEPTH);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_AT    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_NEXT = 2'd1,
    RD_CUR  = 2'd2
  } rd_sel_e;

  typedef enum logic {
    WR_SHIFT = 1'b0,
    WR_VALUE = 1'b1
  } wr_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic    ld;
    cnt_t    at;
    status_e status;
    logic    ptr_ld;
    cnt_t    ptr_val;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_ld;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    cnt_t cnt;
    logic ptr_gt_at;
    logic more_below;
    logic last;
    logic empty;
  } stat_t;

endpackage

>>> design/indexed_list_insert_delete.sv
// Ordered list of up to 32 signed words with insert and delete at the front, the end or
// a given index. Each input item is one command; the block then streams the whole list
// out, one result item per entry in order, tlast on the final one, or a single blank
// result (element_valid low) when the list is empty. A full insert, an empty delete or
// an index out of range leaves the list alone and reports the rejection in status on
// every result item of that command; command codes 6 and 7 change nothing. One command
// is handled at a time: each move of an entry is a read then a write through the list
// memory, after the admission step and before the final insert write or the count
// update; readout then takes a memory read, an output load and an output hold for each
// result, and the output is held while m_axis_tready is low. The list memory is not
// cleared at reset; only the entry count, the pointer and the target index are, and
// nothing beyond the count is ever read out.
module indexed_list_insert_delete
  import ilid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // value[31:0], index[37:32], zero pad
  input  logic [2:0]  s_axis_tuser_i,  // command[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // status[1:0], count_after[7:2], position[12:8],
                                       // element[44:13], zero pad
  output logic        m_axis_tuser_o,  // element_valid[0]
  output logic        m_axis_tlast_o
);

  ctrl_t ctrl;
  stat_t stat;

  logic [1:0]         status;
  logic [5:0]         count_after;
  logic [4:0]         position;
  logic signed [31:0] element;
  logic               element_valid;

  // sequencing: admission, shift loops and readout
  ilid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .cmd_i     (s_axis_tuser_i),
    .index_i   (s_axis_tdata_i[37:32]),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  // list memory, count, pointer and result register
  ilid_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .value_i         (signed'(s_axis_tdata_i[31:0])),
    .stat_o          (stat),
    .status_o        (status),
    .count_after_o   (count_after),
    .position_o      (position),
    .element_o       (element),
    .element_valid_o (element_valid),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, element, position, count_after, status};
  assign m_axis_tuser_o = element_valid;

endmodule

>>> design/ilid_dpath.sv
module ilid_dpath
  import ilid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic signed [31:0] value_i,
  output stat_t              stat_o,
  output logic [1:0]         status_o,
  output logic [5:0]         count_after_o,
  output logic [4:0]         position_o,
  output logic signed [31:0] element_o,
  output logic               element_valid_o,
  output logic               last_o
);

  word_t mem_q [DEPTH];
  word_t rdata_q;
  word_t val_q;
  cnt_t  cnt_q, cnt_d;
  cnt_t  ptr_q, ptr_d;
  cnt_t  at_q;
  addr_t rd_addr, wr_addr;
  word_t wr_data;
  logic [CNT_W:0] ptr_nxt;

  logic [1:0]         status_q;
  logic [5:0]         count_q;
  logic [4:0]         position_q;
  logic signed [31:0] element_q;
  logic               element_valid_q;
  logic               last_q;

  assign ptr_nxt = {1'b0, ptr_q} + 1'b1;

  always_comb begin
    case (ctrl_i.rd_sel)
      RD_PREV: rd_addr = addr_t'(ptr_q - 1'b1);
      RD_NEXT: rd_addr = addr_t'(ptr_nxt);
      RD_CUR:  rd_addr = addr_t'(ptr_q);
      default: rd_addr = addr_t'(ptr_q);
    endcase
  end

  assign wr_addr = addr_t'(ptr_q);
  assign wr_data = (ctrl_i.wr_sel == WR_VALUE) ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.ptr_ld) begin
      ptr_d = ctrl_i.ptr_val;
    end else if (ctrl_i.ptr_inc) begin
      ptr_d = ptr_q + 1'b1;
    end else if (ctrl_i.ptr_dec) begin
      ptr_d = ptr_q - 1'b1;
    end
    cnt_d = cnt_q;
    if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl_i.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      at_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      if (ctrl_i.ld) begin
        at_q <= ctrl_i.at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld) begin
      val_q <= word_t'(value_i);
    end
  end

  // result register; an empty list gives one blank result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_ld) begin
      status_q        <= ctrl_i.status;
      count_q         <= 6'(cnt_q);
      element_valid_q <= stat_o.empty ? 1'b0 : 1'b1;
      last_q          <= stat_o.empty | stat_o.last;
      position_q      <= stat_o.empty ? 5'd0 : 5'(ptr_q);
      element_q       <= stat_o.empty ? 32'sd0 : 32'(signed'(rdata_q));
    end
  end

  assign stat_o.cnt        = cnt_q;
  assign stat_o.ptr_gt_at  = (ptr_q > at_q);
  assign stat_o.more_below = (ptr_nxt < {1'b0, cnt_q});
  assign stat_o.last       = (ptr_nxt == {1'b0, cnt_q});
  assign stat_o.empty      = (cnt_q == '0);

  assign status_o        = status_q;
  assign count_after_o   = count_q;
  assign position_o      = position_q;
  assign element_o       = element_q;
  assign element_valid_o = element_valid_q;
  assign last_o          = last_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cnt_inc |-> (cnt_q < CNT_W'(DEPTH)))
    else $error("insert on full list");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cnt_dec |-> (cnt_q != '0))
    else $error("delete on empty list");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr_en |-> (ptr_q < CNT_W'(DEPTH)) && (ptr_q <= cnt_q))
    else $error("write beyond list end");

endmodule

>>> design/ilid_ctrl.sv
module ilid_ctrl
  import ilid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic [2:0] cmd_i,
  input  logic [5:0] index_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  stat_t      stat_i,
  output ctrl_t      ctrl_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ISH  = 8'b0000_0010,
    S_IWR  = 8'b0000_0100,
    S_DSH  = 8'b0000_1000,
    S_DWR  = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_LD   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  status_e chk;
  cnt_t    at;
  logic    is_ins, is_del;

  // admission check and target position
  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    chk    = ST_DONE;
    at     = '0;
    case (cmd_i)
      CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
        is_ins = 1'b1;
        if (cmd_i == CMD_INS_END) at = stat_i.cnt;
        if (cmd_i == CMD_INS_AT)  at = cnt_t'(index_i);
        if (stat_i.cnt >= CNT_W'(DEPTH)) begin
          chk = ST_FULL;
        end else if (cmd_i == CMD_INS_AT && index_i > stat_i.cnt) begin
          chk = ST_BAD_INDEX;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
        is_del = 1'b1;
        if (cmd_i == CMD_DEL_END) at = stat_i.cnt - 1'b1;
        if (cmd_i == CMD_DEL_AT)  at = cnt_t'(index_i);
        if (stat_i.empty) begin
          chk = ST_EMPTY;
        end else if (cmd_i == CMD_DEL_AT && index_i >= stat_i.cnt) begin
          chk = ST_BAD_INDEX;
        end
      end
      default: ;
    endcase
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    ctrl_o   = '0;
    ctrl_o.status = status_q;
    ctrl_o.at     = at;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          ctrl_o.ld     = 1'b1;
          ctrl_o.ptr_ld = 1'b1;
          status_d      = chk;
          if (chk == ST_DONE && is_ins) begin
            ctrl_o.ptr_val = stat_i.cnt;
            state_d        = S_ISH;
          end else if (chk == ST_DONE && is_del) begin
            ctrl_o.ptr_val = at;
            state_d        = S_DSH;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_ISH: begin
        if (stat_i.ptr_gt_at) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RD_PREV;
          state_d       = S_IWR;
        end else begin
          ctrl_o.wr_en   = 1'b1;
          ctrl_o.wr_sel  = WR_VALUE;
          ctrl_o.cnt_inc = 1'b1;
          ctrl_o.ptr_ld  = 1'b1;
          state_d        = S_RD;
        end
      end
      S_IWR: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_sel  = WR_SHIFT;
        ctrl_o.ptr_dec = 1'b1;
        state_d        = S_ISH;
      end
      S_DSH: begin
        if (stat_i.more_below) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RD_NEXT;
          state_d       = S_DWR;
        end else begin
          ctrl_o.cnt_dec = 1'b1;
          ctrl_o.ptr_ld  = 1'b1;
          state_d        = S_RD;
        end
      end
      S_DWR: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_sel  = WR_SHIFT;
        ctrl_o.ptr_inc = 1'b1;
        state_d        = S_DSH;
      end
      S_RD: begin
        if (stat_i.empty) begin
          ctrl_o.out_ld = 1'b1;
          state_d       = S_OUT;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RD_CUR;
          state_d       = S_LD;
        end
      end
      S_LD: begin
        ctrl_o.out_ld = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (m_ready_i) begin
          if (stat_i.empty || stat_i.last) begin
            state_d = S_IDLE;
          end else begin
            ctrl_o.ptr_inc = 1'b1;
            state_d        = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule
